// ===== src/bounded_array_list_engine_defines.svh =====
// Assertion macros for the bounded array list engine
`ifndef BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTH

`define BLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`define BLE_ASSERT_NEVER(lbl, cond) \
  `BLE_ASSERT(lbl, !(cond))

`else

`define BLE_ASSERT(lbl, prop)

`define BLE_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== src/ble_pkg.sv =====
// Shared constants, codes and control types of the bounded array list engine
`timescale 1ns / 1ps

package ble_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int OP_W    = 2;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 8;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;
  localparam int CAP_W   = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
  localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UPDATE = 2'd3
  } op_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic is_search;
    logic scan_done;
  } sts_t;

endpackage

// ===== src/ble_intf.sv =====
// Request and response channel interfaces
`timescale 1ns / 1ps

interface ble_req_if;
  import ble_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [VALUE_W-1:0] value;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output operation, output value, output index, input ready);
  modport sink   (input valid, input operation, input value, input index, output ready);
endinterface

interface ble_rsp_if;
  import ble_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic signed [POS_W-1:0] position;
  logic [COUNT_W-1:0]      count;

  modport source (output valid, output ok, output position, output count, input ready);
  modport sink   (input valid, input ok, input position, input count, output ready);
endinterface

// ===== src/bounded_array_list_engine.sv =====
// Append, remove and update go from the exec to the hold state; the response is registered
// on leaving hold, once no earlier response is stalled. Search adds the scan state, reading
// one entry per cycle from the single-read-port entry store; the scan stops at the first match.
// Throughput: one request in flight; the next is taken once the previous response is registered.
// Reset: fill count cleared, capacity set to 64; store contents undefined, no clearing pass.
`timescale 1ns / 1ps

module bounded_array_list_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ble_req_if.sink                       req_i,
  ble_rsp_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ble_pkg::PADDR_W-1:0]   paddr,
  input  logic [ble_pkg::PDATA_W-1:0]   pwdata,
  output logic [ble_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ble_pkg::*;

  logic [CAP_W-1:0] capacity_q;
  logic             cap_sel;
  cmd_t             cmd;
  sts_t             sts;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[PADDR_W-1:2] == REG_CAPACITY);
  assign prdata  = cap_sel ? PDATA_W'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  ble_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ble_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (req_i.operation),
    .value_i     (req_i.value),
    .index_i     (req_i.index),
    .capacity_i  (capacity_q),
    .ok_o        (rsp_o.ok),
    .position_o  (rsp_o.position),
    .count_o     (rsp_o.count)
  );

endmodule

// ===== src/ble_ctrl.sv =====
// Controller state machine: request sequencing, scan control, response register valid
`timescale 1ns / 1ps
`include "bounded_array_list_engine_defines.svh"

module ble_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ble_pkg::sts_t sts_i,
  output ble_pkg::cmd_t cmd_o
);
  import ble_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_HOLD
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.load      = in_valid_i && in_ready_o;
    cmd_o.exec      = (state_q == ST_EXEC);
    cmd_o.scan      = (state_q == ST_SCAN);
    cmd_o.publish   = (state_q == ST_HOLD) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          state_q <= sts_i.is_search ? ST_SCAN : ST_HOLD;
        end
        ST_SCAN: begin
          if (sts_i.scan_done) state_q <= ST_HOLD;
        end
        ST_HOLD: begin
          if (cmd_o.publish) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `BLE_ASSERT(a_accept_exec, cmd_o.load |=> (state_q == ST_EXEC))
  `BLE_ASSERT_NEVER(a_publish_overrun, cmd_o.publish && out_valid_q && !out_ready_i)
  `BLE_ASSERT(a_scan_end, (cmd_o.scan && sts_i.scan_done) |=> (state_q == ST_HOLD))

endmodule

// ===== src/ble_dpath.sv =====
// Datapath: entry store, fill count, linear search and response register
`timescale 1ns / 1ps
`include "bounded_array_list_engine_defines.svh"

module ble_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ble_pkg::cmd_t                    cmd_i,
  output ble_pkg::sts_t                    sts_o,
  input  logic [ble_pkg::OP_W-1:0]         operation_i,
  input  logic [ble_pkg::VALUE_W-1:0]      value_i,
  input  logic [ble_pkg::INDEX_W-1:0]      index_i,
  input  logic [ble_pkg::CAP_W-1:0]        capacity_i,
  output logic                             ok_o,
  output logic signed [ble_pkg::POS_W-1:0] position_o,
  output logic [ble_pkg::COUNT_W-1:0]      count_o
);
  import ble_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  op_e                op_q;
  logic [VALUE_W-1:0] val_q;
  logic [INDEX_W-1:0] idx_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   ptr_q;
  logic               rd_vld_q;
  logic [ADDR_W-1:0]  rd_pos_q;
  logic [VALUE_W-1:0] rdata_q;
  logic               found_q;
  logic [ADDR_W-1:0]  fpos_q;
  logic               ok_q;
  logic               res_ok_q;
  logic [POS_W-1:0]   res_pos_q;
  logic [COUNT_W-1:0] res_cnt_q;

  logic              can_append;
  logic              can_remove;
  logic              can_update;
  logic              hit;
  logic              issue;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;

  always_comb begin
    can_append = (32'(count_q) < 32'(capacity_i)) && (32'(count_q) < 32'(DEPTH));
    can_remove = (count_q != '0);
    can_update = (32'(idx_q) < 32'(count_q));
    hit        = rd_vld_q && (rdata_q == val_q);
    issue      = (ptr_q < count_q);
    mem_we     = cmd_i.exec && (((op_q == OP_APPEND) && can_append) ||
                                ((op_q == OP_UPDATE) && can_update));
    mem_waddr  = (op_q == OP_APPEND) ? count_q[ADDR_W-1:0] : ADDR_W'(idx_q);
    sts_o.is_search = (op_q == OP_SEARCH);
    sts_o.scan_done = hit || (!rd_vld_q && !issue);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= val_q;
    rdata_q <= mem[ptr_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(operation_i);
      val_q <= value_i;
      idx_q <= index_i;
    end
    if (cmd_i.scan) begin
      rd_pos_q <= ptr_q[ADDR_W-1:0];
      if (hit) fpos_q <= rd_pos_q;
    end
    if (cmd_i.publish) begin
      res_ok_q  <= (op_q == OP_SEARCH) ? found_q : ok_q;
      res_pos_q <= found_q ? POS_W'(fpos_q) : '1;
      res_cnt_q <= COUNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      ok_q     <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        ptr_q    <= '0;
        rd_vld_q <= 1'b0;
        found_q  <= 1'b0;
        case (op_q)
          OP_APPEND: begin
            ok_q <= can_append;
            if (can_append) count_q <= count_q + 1'b1;
          end
          OP_REMOVE: begin
            ok_q <= can_remove;
            if (can_remove) count_q <= count_q - 1'b1;
          end
          OP_UPDATE: begin
            ok_q <= can_update;
          end
          default: begin
            ok_q <= 1'b0;
          end
        endcase
      end else if (cmd_i.scan) begin
        rd_vld_q <= issue;
        if (issue) ptr_q <= ptr_q + 1'b1;
        if (hit) found_q <= 1'b1;
      end
    end
  end

  assign ok_o       = res_ok_q;
  assign position_o = res_pos_q;
  assign count_o    = res_cnt_q;

  `BLE_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH))
  `BLE_ASSERT(a_read_in_list, (cmd_i.scan && rd_vld_q) |-> (CNT_W'(rd_pos_q) < count_q))
  `BLE_ASSERT(a_append_grows,
              (cmd_i.exec && (op_q == OP_APPEND) && can_append) |=>
              (count_q == $past(count_q) + 1'b1))

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the bounded array list engine: predictor, scoreboard and drivers
`timescale 1ns / 1ps

module tb;
  import ble_pkg::*;

  localparam int unsigned LIMIT       = 1_200_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN       = DEPTH + 16;
  localparam logic signed [POS_W-1:0] NOT_FOUND = -1;
  localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic                    ok;
    logic signed [POS_W-1:0] position;
    logic [COUNT_W-1:0]      count;
  } list_result_t;

  class list_scoreboard;
    logic [VALUE_W-1:0] stored [DEPTH];
    logic [CNT_W-1:0]   fill = '0;
    logic [CAP_W-1:0]   cap = CAP_RESET;
    list_result_t       expected [$];
    int unsigned        mismatches = 0;
    int unsigned        checked = 0;
    int unsigned        search_hits = 0;
    int unsigned        full_refusals = 0;
    int unsigned        peak_fill = 0;

    function void flag(string what, int exp_v, int act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch: %s expected %0d got %0d", $realtime, what, exp_v, act_v);
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    // Predict the response of one accepted request
    function void note_request(op_e op, logic [VALUE_W-1:0] val, logic [INDEX_W-1:0] idx);
      list_result_t r;
      int unsigned  lim;
      int unsigned  i;
      r.ok = 1'b0;
      r.position = NOT_FOUND;
      lim = (cap > DEPTH) ? DEPTH : cap;
      case (op)
        OP_APPEND: begin
          if (fill < lim) begin
            stored[fill] = val;
            fill++;
            r.ok = 1'b1;
          end else begin
            full_refusals++;
          end
        end
        OP_REMOVE: begin
          if (fill > 0) begin
            fill--;
            r.ok = 1'b1;
          end
        end
        OP_SEARCH: begin
          for (i = 0; i < fill && !r.ok; i++) begin
            if (stored[i] == val) begin
              r.ok = 1'b1;
              r.position = POS_W'(i);
              search_hits++;
            end
          end
        end
        OP_UPDATE: begin
          if (idx < fill) begin
            stored[idx] = val;
            r.ok = 1'b1;
          end
        end
      endcase
      r.count = COUNT_W'(fill);
      if (fill > peak_fill) peak_fill = fill;
      expected.push_back(r);
    endfunction

    function void check_response(logic ok, logic signed [POS_W-1:0] pos,
                                 logic [COUNT_W-1:0] cnt);
      list_result_t e;
      checked++;
      if (expected.size() == 0) begin
        flag("response with nothing outstanding, count", -1, cnt);
        return;
      end
      e = expected.pop_front();
      if (ok !== e.ok) flag("ok", e.ok, ok);
      if (pos !== e.position) flag("position", int'(e.position), int'(pos));
      if (cnt !== e.count) flag("count", e.count, cnt);
    endfunction
  endclass

  logic                clk;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  ble_req_if req ();
  ble_rsp_if rsp ();

  list_scoreboard sb;
  bit             no_idle = 1'b0;
  bit             hold_done = 1'b0;
  int unsigned    cycle_count = 0;
  int unsigned    sent = 0;
  int unsigned    settings = 1;

  bounded_array_list_engine DUT (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return VALUE_W'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // Searches mostly look for a word that is held, so hit positions spread
  function automatic logic [VALUE_W-1:0] search_value();
    if (sb.fill > 0 && $urandom_range(0, 99) < 55)
      return sb.stored[$urandom_range(0, int'(sb.fill) - 1)];
    return pick_value();
  endfunction

  function automatic op_e pick_op(int unsigned w_app, int unsigned w_rem, int unsigned w_srch);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < w_app) return OP_APPEND;
    if (r < w_app + w_rem) return OP_REMOVE;
    if (r < w_app + w_rem + w_srch) return OP_SEARCH;
    return OP_UPDATE;
  endfunction

  task automatic send_request(op_e op, logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] ix);
    int unsigned gap;
    gap = no_idle ? 0 : idle_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.value     <= v;
    req.index     <= ix;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(op, v, ix);
    sent++;
  endtask

  task automatic end_phase();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_transfer(logic wr, logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d,
                              output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    logic [PDATA_W-1:0] rd;
    apb_transfer(1'b1, CAP_ADDR, PDATA_W'(c), rd);
    sb.cap = c;
    settings++;
    apb_transfer(1'b0, CAP_ADDR, '0, rd);
    if (rd !== PDATA_W'(c)) sb.flag("capacity read-back", c, int'(rd));
  endtask

  task automatic run_phase(int unsigned n, int unsigned w_app, int unsigned w_rem,
                           int unsigned w_srch);
    op_e                op;
    logic [VALUE_W-1:0] v;
    logic [INDEX_W-1:0] ix;
    int unsigned        k;
    for (k = 0; k < n; k++) begin
      op = pick_op(w_app, w_rem, w_srch);
      v = (op == OP_SEARCH) ? search_value() : pick_value();
      if (op == OP_UPDATE && $urandom_range(0, 3) != 0)
        ix = INDEX_W'($urandom_range(0, sb.fill));
      else
        ix = INDEX_W'($urandom_range(0, 255));
      send_request(op, v, ix);
    end
  endtask

  // Response side: random stalls plus one long hold-off to back the block up
  initial begin : response_sink
    int unsigned stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_ni && rsp.valid && rsp.ready)
        sb.check_response(rsp.ok, rsp.position, rsp.count);
      if (stall_left == 0) begin
        if (!hold_done && sb.checked >= 150) begin
          hold_done = 1'b1;
          stall_left = HOLD_CYCLES;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
          stall_left = idle_gap();
        end
      end
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned caps [8];
    int unsigned lens [8];
    int unsigned p;
    caps = '{127, 1, 64, 0, 10, 100, 33, 64};
    lens = '{260, 150, 220, 60, 180, 200, 180, 150};
    sb = new;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    req.valid     <= 1'b0;
    req.operation <= OP_APPEND;
    req.value     <= '0;
    req.index     <= '0;
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // empty list, then extremes, duplicates, hits, misses and bad indexes
    send_request(OP_REMOVE, 32'h0000_0000, 8'h00);
    send_request(OP_SEARCH, 32'h0000_0000, 8'h00);
    send_request(OP_UPDATE, 32'h1111_1111, 8'h00);
    send_request(OP_APPEND, 32'h8000_0000, 8'h00);
    send_request(OP_APPEND, 32'h7FFF_FFFF, 8'hFF);
    send_request(OP_APPEND, 32'h0000_0000, 8'h00);
    send_request(OP_APPEND, 32'hFFFF_FFFF, 8'h00);
    send_request(OP_APPEND, 32'h7FFF_FFFF, 8'h00);
    send_request(OP_SEARCH, 32'h7FFF_FFFF, 8'h00);
    send_request(OP_SEARCH, 32'hFFFF_FFFF, 8'h00);
    send_request(OP_SEARCH, 32'h8000_0000, 8'h00);
    send_request(OP_SEARCH, 32'h1234_5678, 8'h00);
    send_request(OP_UPDATE, 32'h5A5A_5A5A, 8'h04);
    send_request(OP_UPDATE, 32'hA5A5_A5A5, 8'h05);
    send_request(OP_UPDATE, 32'hA5A5_A5A5, 8'hFF);
    send_request(OP_SEARCH, 32'h5A5A_5A5A, 8'h00);
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_SEARCH, 32'h5A5A_5A5A, 8'h00);
    end_phase();

    // capacity below the fill count
    set_capacity(CAP_W'(2));
    send_request(OP_APPEND, 32'h0BAD_F00D, 8'h00);
    send_request(OP_REMOVE, 32'h0000_0000, 8'h00);
    send_request(OP_REMOVE, 32'h0000_0000, 8'h00);
    send_request(OP_APPEND, 32'h0BAD_F00D, 8'h00);
    send_request(OP_REMOVE, 32'h0000_0000, 8'h00);
    send_request(OP_APPEND, 32'h0BAD_F00D, 8'h00);
    end_phase();

    set_capacity(CAP_W'(0));
    send_request(OP_APPEND, 32'hCAFE_0001, 8'h00);
    send_request(OP_SEARCH, 32'h0BAD_F00D, 8'h00);
    end_phase();

    for (p = 0; p < 8; p++) begin
      set_capacity(CAP_W'(caps[p]));
      no_idle = (p % 3 == 1);
      if (caps[p] >= 33) run_phase(lens[p], 45, 15, 25);
      else run_phase(lens[p], 30, 30, 25);
      end_phase();
    end
    no_idle = 1'b0;

    repeat (DRAIN) @(posedge clk);
    if (sb.pending() != 0) sb.flag("responses never seen", 0, sb.pending());
    $display("Ran %0d requests across %0d capacity settings, peak fill %0d of %0d.",
             sent, settings, sb.peak_fill, DEPTH);
    $display("Search hits %0d, appends refused %0d, responses checked %0d, mismatches %0d.",
             sb.search_hits, sb.full_refusals, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
